/* hdl/wnaf_pkg.sv */
// Shared types, constants and a helper function for the wNAF scalar recoder.
`default_nettype none
package wnaf_pkg;

  // Limits on the configuration
  localparam int MAX_SCALAR_BITS = 512;
  localparam int MAX_WINDOW_BITS = 6;

  // Field and register widths
  localparam int SB_W     = 10;  // scalar_bits register
  localparam int TB_W     = 3;   // window_bits register
  localparam int CFG_W    = 10;  // configuration write data
  localparam int CFG_IDX_W = 1;  // configuration register index
  localparam int POWER_W  = 11;
  localparam int ADDEND_W = 9;
  localparam int COUNT_W  = 10;
  localparam int POS_W    = $clog2(MAX_SCALAR_BITS);
  localparam int ACC_W    = MAX_WINDOW_BITS + 2;  // accumulator stays inside the window

  // Reset values of the registers
  localparam logic [SB_W-1:0] SB_RESET = SB_W'(448);
  localparam logic [TB_W-1:0] TB_RESET = TB_W'(3);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALAR_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BITS = 1'b1;

  // Result slots inside one request record, in delivery order
  localparam int SLOT_A    = 0;  // entry from the input bit
  localparam int SLOT_B    = 1;  // entry from the implicit zero bits
  localparam int SLOT_STOP = 2;  // stopper
  localparam int SLOTS     = 3;

  // Result queue depth, in records
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Recoder state carried from one request to the next
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [POS_W-1:0]        pos;
    logic [COUNT_W-1:0]      emitted;
  } state_t;

  // All results caused by one request
  typedef struct packed {
    logic [SLOTS-1:0]           mask;
    logic signed [POWER_W-1:0]  a_power;
    logic signed [ADDEND_W-1:0] a_addend;
    logic signed [POWER_W-1:0]  b_power;
    logic signed [ADDEND_W-1:0] b_addend;
    logic [COUNT_W-1:0]         count;
  } rec_t;

  // Trailing zero count over the low eight bits of a nonzero digit
  function automatic logic [2:0] trail_zeros(input logic [ADDEND_W-1:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/wnaf_scalar_recoder_core.sv */
// Top level of the wNAF scalar recoder: configuration, recoder state and result queue.
`default_nettype none
// Takes one scalar bit per cycle, most significant first, and produces signed-window
// entries (power, odd addend) plus a stopper that carries the entry count. Each bit is
// handled by one combinational step at acceptance; its results go into a four-record
// queue, so a new bit is accepted every cycle while the queue has a free record, and the
// first result of a bit is offered in the cycle after acceptance if the queue was empty.
// Most bits give zero or one result; the lowest bit of a scalar gives up to three (input
// entry, flush entry, stopper), which leave one per cycle, so throughput drops below one
// bit per cycle only under output stall or with scalars a few bits long. Writing either
// configuration register restarts the current scalar. No clearing pass follows reset.
module wnaf_scalar_recoder_core (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_write,
  input  wire  [wnaf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [wnaf_pkg::CFG_W-1:0]             cfg_data,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire                                    scalar_bit,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [wnaf_pkg::POWER_W-1:0]    power,
  output logic signed [wnaf_pkg::ADDEND_W-1:0]   addend,
  output logic                                   end_of_scalar,
  output logic [wnaf_pkg::COUNT_W-1:0]           entry_count
);
  import wnaf_pkg::*;

  logic [SB_W-1:0]  scalar_bits;
  logic [SB_W-1:0]  scalar_bits_next;
  logic [TB_W-1:0]  window_bits;
  logic [TB_W-1:0]  window_bits_next;
  logic [TB_W-1:0]  window_bits_eff;
  logic [SB_W:0]    sb_eff_next;
  logic [POS_W-1:0] reload_pos;
  state_t           state;
  state_t           step_nxt;
  rec_t             step_rec;
  logic             step_last;
  logic             accept;
  logic             full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // Decode configuration writes
  always_comb begin
    scalar_bits_next = scalar_bits;
    window_bits_next = window_bits;
    if (cfg_write) begin
      case (cfg_index)
        REG_SCALAR_BITS: scalar_bits_next = cfg_data[SB_W-1:0];
        REG_WINDOW_BITS: window_bits_next = cfg_data[TB_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configuration to its usable range
  always_comb begin
    sb_eff_next = {1'b0, scalar_bits_next};
    if (scalar_bits_next == '0) begin
      sb_eff_next = (SB_W+1)'(1);
    end else if ({1'b0, scalar_bits_next} > (SB_W+1)'(MAX_SCALAR_BITS)) begin
      sb_eff_next = (SB_W+1)'(MAX_SCALAR_BITS);
    end
    reload_pos = POS_W'(sb_eff_next - (SB_W+1)'(1));
    window_bits_eff = window_bits;
    if (window_bits > TB_W'(MAX_WINDOW_BITS)) begin
      window_bits_eff = TB_W'(MAX_WINDOW_BITS);
    end
  end

  wnaf_step u_step (
    .cur             (state),
    .scalar_bit      (scalar_bit),
    .window_bits_eff (window_bits_eff),
    .nxt             (step_nxt),
    .rec             (step_rec),
    .last            (step_last)
  );

  // Hold configuration; advance or restart the recoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      scalar_bits   <= SB_RESET;
      window_bits   <= TB_RESET;
      state.acc     <= '0;
      state.pos     <= POS_W'(SB_RESET - SB_W'(1));
      state.emitted <= '0;
    end else begin
      scalar_bits <= scalar_bits_next;
      window_bits <= window_bits_next;
      if (cfg_write || (accept && step_last)) begin
        state.acc     <= '0;
        state.pos     <= reload_pos;
        state.emitted <= '0;
      end else if (accept) begin
        state <= step_nxt;
      end
    end
  end

  wnaf_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .push          (accept && (step_rec.mask != '0)),
    .push_rec      (step_rec),
    .full          (full),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .power         (power),
    .addend        (addend),
    .end_of_scalar (end_of_scalar),
    .entry_count   (entry_count)
  );

`ifndef SYNTH
  a_acc_window: assert property (@(posedge clk) disable iff (rst)
    ((ACC_W+1)'(state.acc) >= -$signed((ACC_W+1)'(1) << ({1'b0, window_bits_eff} + 4'd1)))
    && ((ACC_W+1)'(state.acc) < $signed((ACC_W+1)'(1) << ({1'b0, window_bits_eff} + 4'd1))))
    else $error("accumulator left the window between requests");

  a_stop_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && step_last) |=> ((state.acc == '0) && (state.emitted == '0)))
    else $error("scalar did not restart after its lowest bit");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (POS_W+1)'(state.pos) < (POS_W+1)'(MAX_SCALAR_BITS))
    else $error("bit position beyond scalar length");
`endif

endmodule
`default_nettype wire

/* hdl/wnaf_step.sv */
// One recoding step: doubles and adds the scalar bit, emits window digits and the stopper.
`default_nettype none
module wnaf_step (
  input  wire wnaf_pkg::state_t                cur,
  input  wire                                  scalar_bit,
  input  wire logic [wnaf_pkg::TB_W-1:0]       window_bits_eff,
  output wnaf_pkg::state_t                     nxt,
  output wnaf_pkg::rec_t                       rec,
  output logic                                 last
);
  import wnaf_pkg::*;

  logic signed [ADDEND_W:0]   acc2;
  logic signed [ADDEND_W:0]   hi;
  logic signed [ADDEND_W:0]   sum;
  logic signed [ADDEND_W-1:0] delta;
  logic [2:0]                 tz_a;
  logic [2:0]                 tz_b;
  logic                       emit_a;
  logic                       emit_b;
  logic signed [ACC_W-1:0]    acc_after;
  logic signed [ADDEND_W-1:0] acc_x;

  // Double and add the new bit; check against the window
  always_comb begin
    acc2   = $signed({cur.acc[ACC_W-1], cur.acc, scalar_bit});
    hi     = $signed((ADDEND_W+1)'(1) << ({1'b0, window_bits_eff} + 4'd1));
    emit_a = (acc2 >= hi) || (acc2 < -hi);
    sum    = acc2 + (ADDEND_W+1)'(1);
    delta  = sum[ADDEND_W:1];
    tz_a   = trail_zeros(delta);
  end

  // Leftover accumulator: 0 or -1 after an entry, else the sum itself
  always_comb begin
    if (emit_a) begin
      acc_after = acc2[0] ? -ACC_W'(1) : '0;
    end else begin
      acc_after = acc2[ACC_W-1:0];
    end
    acc_x  = {{(ADDEND_W-ACC_W){acc_after[ACC_W-1]}}, acc_after};
    tz_b   = trail_zeros(acc_x);
    last   = (cur.pos == '0);
    // Trailing zero bits flush any nonzero leftover as its odd part
    emit_b = last && (acc_after != '0);
  end

  // Assemble the request record
  always_comb begin
    rec.mask            = '0;
    rec.mask[SLOT_A]    = emit_a;
    rec.mask[SLOT_B]    = emit_b;
    rec.mask[SLOT_STOP] = last;
    rec.a_power  = $signed(POWER_W'(cur.pos) + POWER_W'(tz_a) + POWER_W'(1));
    rec.a_addend = delta >>> tz_a;
    rec.b_power  = $signed(POWER_W'(tz_b));
    rec.b_addend = acc_x >>> tz_b;
    rec.count    = cur.emitted + COUNT_W'(emit_a) + COUNT_W'(emit_b);
  end

  // Continue with the next lower bit
  always_comb begin
    nxt.acc     = acc_after;
    nxt.pos     = cur.pos - POS_W'(1);
    nxt.emitted = cur.emitted + COUNT_W'(emit_a);
  end

endmodule
`default_nettype wire

/* hdl/wnaf_queue.sv */
// Result queue: holds request records and delivers their results one at a time.
`default_nettype none
module wnaf_queue (
  input  wire                                         clk,
  input  wire                                         rst,
  input  wire                                         push,
  input  wire wnaf_pkg::rec_t                         push_rec,
  output logic                                        full,
  output logic                                        out_valid,
  input  wire                                         out_stall,
  output logic signed [wnaf_pkg::POWER_W-1:0]         power,
  output logic signed [wnaf_pkg::ADDEND_W-1:0]        addend,
  output logic                                        end_of_scalar,
  output logic [wnaf_pkg::COUNT_W-1:0]                entry_count
);
  import wnaf_pkg::*;

  rec_t              mem [QDEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QPTR_W:0]   count;
  logic [SLOTS-1:0]  done;
  logic [SLOTS-1:0]  done_next;
  rec_t              hrec;
  logic [SLOTS-1:0]  pending;
  logic [SLOTS-1:0]  cur;
  logic              take;
  logic              pop;
  logic              wr;

  assign full      = (count == (QPTR_W+1)'(QDEPTH));
  assign out_valid = (count != '0);
  assign wr        = push && !full;
  assign hrec      = mem[head];
  assign pending   = hrec.mask & ~done;
  assign take      = out_valid && !out_stall;
  assign pop       = take && ((pending & ~cur) == '0);

  // Pick the first pending result of the head record
  always_comb begin
    cur           = '0;
    power         = -POWER_W'(1);
    addend        = '0;
    end_of_scalar = 1'b0;
    entry_count   = '0;
    if (pending[SLOT_A]) begin
      cur[SLOT_A] = 1'b1;
      power       = hrec.a_power;
      addend      = hrec.a_addend;
    end else if (pending[SLOT_B]) begin
      cur[SLOT_B] = 1'b1;
      power       = hrec.b_power;
      addend      = hrec.b_addend;
    end else begin
      cur[SLOT_STOP] = 1'b1;
      end_of_scalar  = 1'b1;
      entry_count    = hrec.count;
    end
  end

  // Mark delivered results; clear when the record leaves
  always_comb begin
    done_next = done;
    if (pop) begin
      done_next = '0;
    end else if (take) begin
      done_next = done | cur;
    end
  end

  // Store records
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[tail] <= push_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      done  <= '0;
    end else begin
      done <= done_next;
      if (wr) tail <= tail + QPTR_W'(1);
      if (pop) head <= head + QPTR_W'(1);
      count <= count + (QPTR_W+1)'(wr) - (QPTR_W+1)'(pop);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue occupancy above depth");

  a_head_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != '0))
    else $error("head record shown with no result left");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (take && !pop) |=> ($stable(head) && (done != '0)))
    else $error("head record moved before all its results left");
`endif

endmodule
`default_nettype wire

/* tb/wnaf_scalar_recoder_core_test.sv */
// Self-checking testbench for the wNAF scalar recoder: directed table, random phases, scoreboard.
`default_nettype none
module wnaf_scalar_recoder_core_test;
  import wnaf_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int RANDOM_BITS = 86;
  localparam int N_DIRECTED  = 30;

  // One recoded entry as it leaves the block
  typedef struct packed {
    logic signed [POWER_W-1:0]  power;
    logic signed [ADDEND_W-1:0] addend;
    logic                       eos;
    logic [COUNT_W-1:0]         count;
  } entry_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_BIT, ROW_TYPED} row_kind_e;

  // Directed row: register write, predicted bit, or bit with hand-written results
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
    logic                   b;
    logic [1:0]             n_typed;
  } row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]             cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         scalar_bit = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [POWER_W-1:0]    power;
  logic signed [ADDEND_W-1:0]   addend;
  logic                         end_of_scalar;
  logic [COUNT_W-1:0]           entry_count;

  wnaf_scalar_recoder_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .scalar_bit    (scalar_bit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .power         (power),
    .addend        (addend),
    .end_of_scalar (end_of_scalar),
    .entry_count   (entry_count)
  );

  always #5 clk = ~clk;

  // Directed stimulus; typed rows carry results readable by hand
  row_t directed [N_DIRECTED] = '{
    '{ROW_TYPED, REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_CFG,   REG_SCALAR_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_CFG,   REG_WINDOW_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_TYPED, REG_SCALAR_BITS, 10'd0,     1'b1, 2'd2},
    '{ROW_TYPED, REG_SCALAR_BITS, 10'd0,     1'b0, 2'd1},
    '{ROW_CFG,   REG_WINDOW_BITS, 10'h3FF,   1'b0, 2'd0},
    '{ROW_TYPED, REG_SCALAR_BITS, 10'd0,     1'b1, 2'd2},
    '{ROW_TYPED, REG_SCALAR_BITS, 10'd0,     1'b0, 2'd1},
    '{ROW_CFG,   REG_SCALAR_BITS, 10'h3FF,   1'b0, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b0, 2'd0},
    '{ROW_CFG,   REG_WINDOW_BITS, 10'h3F9,   1'b0, 2'd0},
    '{ROW_CFG,   REG_SCALAR_BITS, 10'd2,     1'b0, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0},
    '{ROW_BIT,   REG_SCALAR_BITS, 10'd0,     1'b1, 2'd0}
  };

  // Hand-written results of the typed rows, consumed in order
  entry_t typed_results [6] = '{
    '{11'sd0,  9'sd1, 1'b0, 10'd0},
    '{-11'sd1, 9'sd0, 1'b1, 10'd1},
    '{-11'sd1, 9'sd0, 1'b1, 10'd0},
    '{11'sd0,  9'sd1, 1'b0, 10'd0},
    '{-11'sd1, 9'sd0, 1'b1, 10'd1},
    '{-11'sd1, 9'sd0, 1'b1, 10'd0}
  };
  int typed_next = 0;

  // Recoder shadow state and registers
  logic [SB_W-1:0] sb_reg;
  logic [TB_W-1:0] tb_reg;
  int              acc;
  int              bitpos;
  int              n_emitted;
  entry_t          fresh[$];
  entry_t          pending_entries[$];

  int  errors = 0;
  bit  quiet = 1'b0;

  function automatic int eff_scalar_bits();
    int n;
    n = sb_reg;
    if (n == 0) n = 1;
    if (n > MAX_SCALAR_BITS) n = MAX_SCALAR_BITS;
    return n;
  endfunction

  function automatic int eff_window_bits();
    int t;
    t = tb_reg;
    if (t > MAX_WINDOW_BITS) t = MAX_WINDOW_BITS;
    return t;
  endfunction

  function automatic void restart_scalar();
    acc = 0;
    bitpos = eff_scalar_bits() - 1;
    n_emitted = 0;
  endfunction

  // Double and add one bit; emit an entry when the window is left
  function automatic int window_step(input int pos, input int b);
    int     lim;
    int     v;
    int     d;
    int     j;
    entry_t e;
    lim = 1 << (eff_window_bits() + 1);
    acc = acc * 2 + b;
    if (!(acc >= lim || acc <= -1 - lim)) return 0;
    v = acc + 1;
    d = (v >= 0) ? v / 2 : -((-v + 1) / 2);
    acc = acc[0] ? -1 : 0;
    j = pos;
    // strip trailing zeros, moving the power up
    while (d != 0 && d[0] == 1'b0) begin
      d = d / 2;
      j++;
    end
    e.power = POWER_W'(j + 1);
    e.addend = ADDEND_W'(d);
    e.eos = 1'b0;
    e.count = '0;
    fresh.push_back(e);
    n_emitted = (n_emitted + 1) % 1024;
    return 1;
  endfunction

  // Recode one accepted bit into fresh
  function automatic void recode_bit(input logic b);
    int     pos;
    int     made;
    entry_t e;
    pos = bitpos;
    made = window_step(pos, int'(b));
    if (pos == 0) begin
      // flush the implicit zero bits, then close the scalar
      for (int m = 1; m <= eff_window_bits() + 2; m++) begin
        if (made < 2) made += window_step(-m, 0);
      end
      e.power = -POWER_W'(1);
      e.addend = '0;
      e.eos = 1'b1;
      e.count = COUNT_W'(n_emitted);
      fresh.push_back(e);
      restart_scalar();
    end else begin
      bitpos = pos - 1;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Drive one request and queue its expected entries once accepted
  task automatic send_bit(input logic b, input bit use_typed, input int n_typed);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    scalar_bit <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fresh.delete();
    recode_bit(b);
    if (use_typed) begin
      repeat (n_typed) begin
        pending_entries.push_back(typed_results[typed_next]);
        typed_next++;
      end
    end else begin
      foreach (fresh[i]) pending_entries.push_back(fresh[i]);
    end
  endtask

  // Drop valid and wait for the block to drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SCALAR_BITS) sb_reg = data[SB_W-1:0];
    else sb_reg = sb_reg;
    if (idx == REG_WINDOW_BITS) tb_reg = data[TB_W-1:0];
    restart_scalar();
    @(posedge clk);
  endtask

  // Random stall on the result side
  always @(posedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(0, 99) < 31);
  end

  // Compare each delivered entry with the oldest expectation
  always @(posedge clk) begin
    entry_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_entries.size() == 0) begin
        report_mismatch("unexpected entry, power", power, 0);
      end else begin
        want = pending_entries.pop_front();
        if (power !== want.power) report_mismatch("power", power, want.power);
        if (addend !== want.addend) report_mismatch("addend", addend, want.addend);
        if (end_of_scalar !== want.eos)
          report_mismatch("end_of_scalar", end_of_scalar, want.eos);
        if (entry_count !== want.count)
          report_mismatch("entry_count", entry_count, want.count);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("wnaf_scalar_recoder_core_test failed");
    $finish;
  end

  initial begin
    int         sent;
    int         phase;
    int         n_bits;
    int         mode;
    logic       b;
    logic [CFG_W-1:0] sb_val;
    sb_reg = SB_RESET;
    tb_reg = TB_RESET;
    restart_scalar();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    for (int r = 0; r < N_DIRECTED; r++) begin
      case (directed[r].kind)
        ROW_CFG: begin
          settle();
          write_reg(directed[r].idx, directed[r].data);
        end
        ROW_BIT: begin
          send_bit(directed[r].b, 1'b0, 0);
        end
        default: begin
          send_bit(directed[r].b, 1'b1, int'(directed[r].n_typed));
        end
      endcase
    end

    // Random phases: new settings at random, then a burst of random bits, uniform or biased
    sent = 0;
    phase = 0;
    while (sent < RANDOM_BITS) begin
      settle();
      quiet = (phase == 2 || phase == 3);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: sb_val = '0;
          1: sb_val = CFG_W'($urandom_range(MAX_SCALAR_BITS, 1023));
          default: sb_val = CFG_W'($urandom_range(1, 12));
        endcase
        write_reg(REG_SCALAR_BITS, sb_val);
      end
      if ($urandom_range(0, 1) != 0) write_reg(REG_WINDOW_BITS, CFG_W'($urandom_range(0, 1023)));
      mode = $urandom_range(0, 2);
      n_bits = $urandom_range(4, 20);
      for (int i = 0; i < n_bits && sent < RANDOM_BITS; i++) begin
        case (mode)
          0: b = 1'($urandom_range(0, 1));
          1: b = ($urandom_range(0, 9) != 0);
          default: b = ($urandom_range(0, 9) == 0);
        endcase
        send_bit(b, 1'b0, 0);
        sent++;
      end
      phase++;
    end
    quiet = 1'b0;

    // Drain, then wait for stray entries
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_entries.size() == 0) begin
      $display("wnaf_scalar_recoder_core_test passed");
    end else begin
      $display("wnaf_scalar_recoder_core_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
